@@ hw/rtl/bcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and codes of the boosted cascade classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  typedef enum logic [2:0] {
    KIND_FEATURE  = 3'd0,
    KIND_WEAK     = 3'd1,
    KIND_TABLE    = 3'd2,
    KIND_STAGE    = 3'd3,
    KIND_CLASSIFY = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [12:0]        feature_index;
    logic [7:0]         feature_code;
    logic [4:0]         stage_index;
    logic [4:0]         weak_slot;
    logic [7:0]         table_bin;
    logic signed [15:0] table_value;
    logic [5:0]         weak_count;
    logic signed [23:0] threshold_value;
    logic               true_class;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAGE,
    ST_SEL,
    ST_FEAT,
    ST_TAB,
    ST_ACC,
    ST_CHECK,
    ST_FINISH
  } state_t;

  localparam logic [1:0] OUT_TP = 2'd0;
  localparam logic [1:0] OUT_FN = 2'd1;
  localparam logic [1:0] OUT_TN = 2'd2;
  localparam logic [1:0] OUT_FP = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

@@ hw/rtl/bcc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_front
// Takes input requests, decodes the kind and pushes commands to the queue.
// ----------------------------------------------------------------------------
module bcc_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [12:0]        feature_index,
  input  logic [7:0]         feature_code,
  input  logic [4:0]         stage_index,
  input  logic [4:0]         weak_slot,
  input  logic [7:0]         table_bin,
  input  logic signed [15:0] table_value,
  input  logic [5:0]         weak_count,
  input  logic signed [23:0] threshold_value,
  input  logic               true_class,
  input  logic               q_full,
  output logic               q_push,
  output bcc_pkg::cmd_t      q_cmd
);
  import bcc_pkg::*;

  logic known;

  always_comb begin
    case (kind)
      KIND_FEATURE, KIND_WEAK, KIND_TABLE, KIND_STAGE,
      KIND_CLASSIFY, KIND_CLEAR: known = 1'b1;
      default:                   known = 1'b0;
    endcase
  end

  // unknown kinds are taken and dropped
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && known;

  always_comb begin
    q_cmd.kind            = kind_t'(kind);
    q_cmd.feature_index   = feature_index;
    q_cmd.feature_code    = feature_code;
    q_cmd.stage_index     = stage_index;
    q_cmd.weak_slot       = weak_slot;
    q_cmd.table_bin       = table_bin;
    q_cmd.table_value     = table_value;
    q_cmd.weak_count      = weak_count;
    q_cmd.threshold_value = threshold_value;
    q_cmd.true_class      = true_class;
  end

endmodule

@@ hw/rtl/bcc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_queue
// Small command queue between the front and the engine.
// ----------------------------------------------------------------------------
module bcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bcc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bcc_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import bcc_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

@@ hw/rtl/bcc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_engine
// Executes queued commands: table loads, cascade walk and confusion counts.
// ----------------------------------------------------------------------------
module bcc_engine #(
  parameter int FEATURE_DEPTH = 8192,
  parameter int MAX_STAGES    = 32,
  parameter int MAX_WEAK      = 32,
  parameter int TABLE_BINS    = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  bcc_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  input  logic [5:0]    stage_count,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          face_detected,
  output logic [5:0]    reject_stage,
  output logic [1:0]    outcome,
  output logic [31:0]   true_pos_total,
  output logic [31:0]   false_neg_total,
  output logic [31:0]   true_neg_total,
  output logic [31:0]   false_pos_total
);
  import bcc_pkg::*;

  localparam int FAW   = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
  localparam int STW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int WW    = (MAX_WEAK > 1) ? $clog2(MAX_WEAK) : 1;
  localparam int BINW  = $clog2(TABLE_BINS);
  localparam int WCW   = $clog2(MAX_WEAK + 1);
  localparam int NSW   = $clog2(MAX_STAGES + 1);
  localparam int SELA  = STW + WW;
  localparam int TABA  = SELA + BINW;
  localparam int SUM_W = 26 + WCW;

  state_t state, state_next;

  // cascade memories, valid only once written
  logic [7:0]         feat_mem  [FEATURE_DEPTH];
  logic [12:0]        sel_mem   [2**SELA];
  logic signed [15:0] table_mem [2**TABA];

  logic [WCW-1:0]     weak_tot [MAX_STAGES];
  logic signed [23:0] offset   [MAX_STAGES];

  logic [7:0]         feat_q;
  logic               feat_ok;
  logic [12:0]        sel_q;
  logic signed [15:0] tab_q;

  logic [STW-1:0]     stage;
  logic [WW-1:0]      weak_idx;
  logic [WCW-1:0]     nw_q;
  logic signed [SUM_W-1:0] sum;
  logic               det_q;
  logic [5:0]         rej_q;
  logic               label_q;

  logic [NSW-1:0]     n_st;
  logic               last_stage;
  logic               last_weak;
  logic               out_free;
  logic [WCW-1:0]     wcnt_clip;

  logic               feat_we, sel_we, tab_we, stage_we, clear_cnt;
  logic [FAW-1:0]     feat_raddr;
  logic [SELA-1:0]    sel_addr_rd;
  logic [TABA-1:0]    tab_raddr;

  assign n_st = (32'(stage_count) > MAX_STAGES) ? NSW'(MAX_STAGES) : NSW'(stage_count);
  assign last_stage = (32'(stage) + 1 == 32'(n_st));
  assign last_weak  = (32'(weak_idx) + 1 == 32'(nw_q));
  assign out_free   = !out_valid || out_ready;
  assign wcnt_clip  = (32'(head.weak_count) > MAX_WEAK) ? WCW'(MAX_WEAK)
                                                        : WCW'(head.weak_count);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty && head.kind == KIND_CLASSIFY) begin
          state_next = (n_st == '0) ? ST_FINISH : ST_STAGE;
        end
      end
      ST_STAGE: state_next = (weak_tot[stage] == '0) ? ST_CHECK : ST_SEL;
      ST_SEL:   state_next = ST_FEAT;
      ST_FEAT:  state_next = ST_TAB;
      ST_TAB:   state_next = ST_ACC;
      ST_ACC:   state_next = last_weak ? ST_CHECK : ST_SEL;
      ST_CHECK: state_next = (sum < 0 || last_stage) ? ST_FINISH : ST_STAGE;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    feat_we   = 1'b0;
    sel_we    = 1'b0;
    tab_we    = 1'b0;
    stage_we  = 1'b0;
    clear_cnt = 1'b0;
    case (state)
      ST_IDLE: begin
        // a clear holds back while a result still shows the totals
        if (!empty && (head.kind != KIND_CLEAR || out_free)) begin
          pop = 1'b1;
          case (head.kind)
            KIND_FEATURE: feat_we = (32'(head.feature_index) < FEATURE_DEPTH);
            KIND_WEAK: sel_we = (32'(head.stage_index) < MAX_STAGES) &&
                                (32'(head.weak_slot) < MAX_WEAK);
            KIND_TABLE: tab_we = (32'(head.stage_index) < MAX_STAGES) &&
                                 (32'(head.weak_slot) < MAX_WEAK);
            KIND_STAGE: stage_we = (32'(head.stage_index) < MAX_STAGES);
            KIND_CLEAR: clear_cnt = 1'b1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign sel_addr_rd = {stage, weak_idx};
  assign feat_raddr  = FAW'(sel_q);
  assign tab_raddr   = {stage, weak_idx, feat_ok ? BINW'(feat_q) : BINW'(0)};

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[FAW'(head.feature_index)] <= head.feature_code;
    end
    feat_q <= feat_mem[feat_raddr];
  end

  always_ff @(posedge clk) begin
    if (sel_we) begin
      sel_mem[{STW'(head.stage_index), WW'(head.weak_slot)}] <= head.feature_index;
    end
    sel_q <= sel_mem[sel_addr_rd];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      table_mem[{STW'(head.stage_index), WW'(head.weak_slot), BINW'(head.table_bin)}]
        <= head.table_value;
    end
    tab_q <= table_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        weak_tot[i] <= '0;
        offset[i]   <= '0;
      end
    end else if (stage_we) begin
      weak_tot[STW'(head.stage_index)] <= wcnt_clip;
      offset[STW'(head.stage_index)]   <= head.threshold_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      true_pos_total  <= '0;
      false_neg_total <= '0;
      true_neg_total  <= '0;
      false_pos_total <= '0;
    end else begin
      state <= state_next;
      if (clear_cnt) begin
        true_pos_total  <= '0;
        false_neg_total <= '0;
        true_neg_total  <= '0;
        false_pos_total <= '0;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
        if (label_q && det_q) begin
          if (true_pos_total != '1) true_pos_total <= true_pos_total + 1'b1;
        end else if (label_q) begin
          if (false_neg_total != '1) false_neg_total <= false_neg_total + 1'b1;
        end else if (!det_q) begin
          if (true_neg_total != '1) true_neg_total <= true_neg_total + 1'b1;
        end else begin
          if (false_pos_total != '1) false_pos_total <= false_pos_total + 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        label_q <= head.true_class;
        stage   <= '0;
        det_q   <= 1'b1;
        rej_q   <= 6'(n_st);
      end
      ST_STAGE: begin
        nw_q     <= weak_tot[stage];
        sum      <= SUM_W'(offset[stage]);
        weak_idx <= '0;
      end
      ST_FEAT: feat_ok <= (32'(sel_q) < FEATURE_DEPTH);
      ST_ACC: begin
        sum      <= sum + SUM_W'(tab_q);
        weak_idx <= weak_idx + 1'b1;
      end
      ST_CHECK: begin
        if (sum < 0) begin
          det_q <= 1'b0;
          rej_q <= 6'(stage);
        end else begin
          stage <= stage + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          face_detected <= det_q;
          reject_stage  <= rej_q;
          if (label_q) begin
            outcome <= det_q ? OUT_TP : OUT_FN;
          end else begin
            outcome <= det_q ? OUT_FP : OUT_TN;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/boosted_cascade_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boosted_cascade_classifier
// Boosted cascade of lookup-table weak classifiers over stored feature codes.
// ----------------------------------------------------------------------------
// load and clear requests: one per cycle while the engine is idle and the queue has room,
//   written once popped from the queue; a clear also waits until any held result has been taken
// classify: walks the stages in order, one weak classifier at a time through three
//   dependent memory reads
// reset: stage table, counters and stage count cleared at once; the feature,
//   selector and response memories hold nothing until written
module boosted_cascade_classifier #(
  parameter int FEATURE_DEPTH = 8192,
  parameter int MAX_STAGES    = 32,
  parameter int MAX_WEAK      = 32,
  parameter int TABLE_BINS    = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [12:0]        feature_index,
  input  logic [7:0]         feature_code,
  input  logic [4:0]         stage_index,
  input  logic [4:0]         weak_slot,
  input  logic [7:0]         table_bin,
  input  logic signed [15:0] table_value,
  input  logic [5:0]         weak_count,
  input  logic signed [23:0] threshold_value,
  input  logic               true_class,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               face_detected,
  output logic [5:0]         reject_stage,
  output logic [1:0]         outcome,
  output logic [31:0]        true_pos_total,
  output logic [31:0]        false_neg_total,
  output logic [31:0]        true_neg_total,
  output logic [31:0]        false_pos_total
);
  import bcc_pkg::*;

  logic [5:0] stage_count;
  logic       q_push, q_pop, q_empty, q_full;
  cmd_t       q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= '0;
    end else if (cfg_valid) begin
      stage_count <= cfg_data;
    end
  end

  bcc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .feature_index   (feature_index),
    .feature_code    (feature_code),
    .stage_index     (stage_index),
    .weak_slot       (weak_slot),
    .table_bin       (table_bin),
    .table_value     (table_value),
    .weak_count      (weak_count),
    .threshold_value (threshold_value),
    .true_class      (true_class),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  bcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bcc_engine #(
    .FEATURE_DEPTH (FEATURE_DEPTH),
    .MAX_STAGES    (MAX_STAGES),
    .MAX_WEAK      (MAX_WEAK),
    .TABLE_BINS    (TABLE_BINS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .stage_count     (stage_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .face_detected   (face_detected),
    .reject_stage    (reject_stage),
    .outcome         (outcome),
    .true_pos_total  (true_pos_total),
    .false_neg_total (false_neg_total),
    .true_neg_total  (true_neg_total),
    .false_pos_total (false_pos_total)
  );

  // outcome code agrees with the detection flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outcome[0] == (outcome[1] ? face_detected : !face_detected)))
    else $error("outcome does not match detection");

  // an accepted sample reports the effective stage count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && face_detected |->
      (32'(reject_stage) == ((32'(stage_count) > MAX_STAGES) ? MAX_STAGES
                                                             : 32'(stage_count))))
    else $error("accept stage differs from stage count");

  // a rejection names a stage in use
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !face_detected |-> (reject_stage < stage_count))
    else $error("reject stage out of range");

  // the queue is never pushed when full
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("command queue overflow");

endmodule
